/* sv/ncae_pkg.sv */
// ----------------------------------------------------------------------------
// ncae_pkg: shared types for the name cache
// Command codes and the controller-to-datapath command and status records.
// ----------------------------------------------------------------------------
package ncae_pkg;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // datapath operation selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,     // capture input item, clear result
        OP_SCAN_RD,   // issue read of entry at scan index
        OP_SCAN_CHK,  // compare entry read last cycle
        OP_DIV_INIT,  // load divider
        OP_DIV_STEP,  // one quotient bit
        OP_DIV_DONE,  // form threshold
        OP_SWEEP_CHK, // drop entry if older than threshold
        OP_HIT,       // refresh time of hit entry
        OP_WRITE,     // write insert into chosen slot
        OP_REFUSE     // flag refused insert
    } t_op;

    typedef struct packed {
        t_op  op;
        logic scan_reset;   // restart scan index at zero
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic table_full;
        logic scan_last;    // scan index is at the last entry
        logic div_last;     // final divider step
        logic thr_zero;     // threshold wrapped to zero
        logic key_hit;      // a matching key has been seen in the scan
        logic free_seen;    // a free slot has been seen in the scan
    } t_status;

endpackage

/* sv/ncae_ctrl.sv */
// ----------------------------------------------------------------------------
// ncae_ctrl: sequencer for lookups and inserts
// Walks each item's scan; a full-table insert adds threshold division, sweep.
// ----------------------------------------------------------------------------
module ncae_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ncae_pkg::t_status  i_status,
    output ncae_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_DIV, S_DIV_END, S_SWEEP_RD, S_SWEEP_CHK,
        S_POST, S_SCAN_RD, S_SCAN_CHK, S_DECIDE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and command decode
    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        o_cmd.op        = ncae_pkg::OP_NONE;
        o_cmd.scan_reset = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ncae_pkg::OP_LATCH;
                    n_state  = S_START;
                end
            end
            S_START: begin
                o_cmd.scan_reset = 1'b1;
                if (i_status.is_insert && i_status.table_full) begin
                    o_cmd.op = ncae_pkg::OP_DIV_INIT;
                    n_state  = S_DIV;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DIV: begin
                o_cmd.op = ncae_pkg::OP_DIV_STEP;
                if (i_status.div_last) n_state = S_DIV_END;
            end
            S_DIV_END: begin
                o_cmd.op = ncae_pkg::OP_DIV_DONE;
                n_state  = S_SWEEP_RD;
            end
            S_SWEEP_RD: begin
                if (i_status.thr_zero) begin
                    n_state = S_POST;
                end else begin
                    o_cmd.op = ncae_pkg::OP_SCAN_RD;
                    n_state  = S_SWEEP_CHK;
                end
            end
            S_SWEEP_CHK: begin
                o_cmd.op = ncae_pkg::OP_SWEEP_CHK;
                n_state  = i_status.scan_last ? S_POST : S_SWEEP_RD;
            end
            S_POST: begin
                o_cmd.scan_reset = 1'b1;
                if (i_status.table_full) begin
                    o_cmd.op    = ncae_pkg::OP_REFUSE;
                    n_out_valid = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.op = ncae_pkg::OP_SCAN_RD;
                n_state  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.op = ncae_pkg::OP_SCAN_CHK;
                n_state  = i_status.scan_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE: begin
                n_out_valid = 1'b1;
                n_state     = S_DONE;
                if (i_status.is_insert) begin
                    o_cmd.op = (i_status.key_hit || i_status.free_seen)
                             ? ncae_pkg::OP_WRITE : ncae_pkg::OP_REFUSE;
                end else if (i_status.key_hit) begin
                    o_cmd.op = ncae_pkg::OP_HIT;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_valid_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_DONE))
        else $error("result valid outside done state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped before transfer");

endmodule

/* sv/ncae_dp.sv */
// ----------------------------------------------------------------------------
// ncae_dp: entry store, running time sum, divider and result register
// Entries live in a memory with one read port; valid bits in flops.
// ----------------------------------------------------------------------------
module ncae_dp #(
    parameter int CAPACITY   = 256,
    parameter int TIME_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ncae_pkg::t_cmd     i_cmd,
    output ncae_pkg::t_status  o_status,
    input  logic               i_cmd_bit,
    input  logic [63:0]        i_name_key,
    input  logic [31:0]        i_now_seconds,
    input  logic [1:0]         i_addr_family,
    input  logic [63:0]        i_addr_high,
    input  logic [63:0]        i_addr_low,
    output logic               o_found,
    output logic [1:0]         o_result_family,
    output logic [63:0]        o_result_addr_high,
    output logic [63:0]        o_result_addr_low,
    output logic               o_insert_refused,
    output logic [8:0]         o_entries_in_use
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = TIME_WIDTH + CW;
    localparam int EW = 64 + 2 + 64 + 64 + TIME_WIDTH;
    localparam int DW = $clog2(SW + 1);

    typedef struct packed {
        logic [63:0]           key;
        logic [1:0]            fam;
        logic [63:0]           ahi;
        logic [63:0]           alo;
        logic [TIME_WIDTH-1:0] t;
    } t_entry;

    t_entry                r_mem [CAPACITY];
    t_entry                r_rd;
    logic [CAPACITY-1:0]   r_valid;
    logic [IW-1:0]         r_idx, r_rd_idx;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_sum;
    logic [TIME_WIDTH-1:0] r_thr;
    logic                  r_is_ins;
    logic [63:0]           r_key;
    logic [TIME_WIDTH-1:0] r_now;
    logic [1:0]            r_fam;
    logic [63:0]           r_ahi, r_alo;
    logic                  r_hit, r_free;
    logic [IW-1:0]         r_hit_idx, r_free_idx;
    logic [TIME_WIDTH-1:0] r_hit_t;
    logic [SW-1:0]         r_quo, r_rem_num;
    logic [CW-1:0]         r_rem;
    logic [DW-1:0]         r_div_cnt;
    logic                  r_found, r_refused;
    logic [1:0]            r_rfam;
    logic [63:0]           r_rhi, r_rlo;

    logic [CW:0]           w_trial;
    logic [SW:0]           w_thr_full;
    logic                  w_rd_valid;
    t_entry                w_new;

    assign w_trial    = {r_rem, r_rem_num[SW-1]};
    assign w_thr_full = {1'b0, r_quo} + {{SW{1'b0}}, 1'b1};
    assign w_rd_valid = r_valid[r_rd_idx];
    assign w_new      = '{key: r_key, fam: r_fam, ahi: r_ahi, alo: r_alo, t: r_now};

    // status to controller
    assign o_status.is_insert  = r_is_ins;
    assign o_status.table_full = (r_count >= CW'(CAPACITY));
    assign o_status.scan_last  = (r_rd_idx == IW'(CAPACITY - 1));
    assign o_status.div_last   = (r_div_cnt == DW'(SW - 1));
    assign o_status.thr_zero   = (r_thr == '0);
    assign o_status.key_hit    = r_hit;
    assign o_status.free_seen  = r_free;

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ncae_pkg::OP_SCAN_RD) begin
            r_rd <= r_mem[r_idx];
        end
        if (i_cmd.op == ncae_pkg::OP_HIT) begin
            r_mem[r_hit_idx].t <= r_now;
        end else if (i_cmd.op == ncae_pkg::OP_WRITE) begin
            r_mem[r_hit ? r_hit_idx : r_free_idx] <= w_new;
        end
    end

    // control state: valid bits, count, sum, scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_thr   <= '0;
            r_idx   <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.scan_reset) r_idx <= '0;
            unique case (i_cmd.op)
                ncae_pkg::OP_SCAN_RD: begin
                    r_rd_idx <= r_idx;
                    r_idx    <= r_idx + IW'(1);
                end
                ncae_pkg::OP_DIV_DONE: r_thr <= w_thr_full[TIME_WIDTH-1:0];
                ncae_pkg::OP_SWEEP_CHK: begin
                    if (w_rd_valid && (r_rd.t < r_thr)) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_sum   <= r_sum - SW'(r_rd.t);
                        r_count <= r_count - CW'(1);
                    end
                end
                ncae_pkg::OP_HIT: r_sum <= r_sum - SW'(r_hit_t) + SW'(r_now);
                ncae_pkg::OP_WRITE: begin
                    if (r_hit) begin
                        r_sum <= r_sum - SW'(r_hit_t) + SW'(r_now);
                    end else begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_count <= r_count + CW'(1);
                        r_sum   <= r_sum + SW'(r_now);
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture, scan match tracking, divider, result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ncae_pkg::OP_LATCH: begin
                r_is_ins  <= (i_cmd_bit == ncae_pkg::CMD_INSERT);
                r_key     <= i_name_key;
                r_now     <= TIME_WIDTH'(i_now_seconds);
                r_fam     <= i_addr_family;
                r_ahi     <= i_addr_high;
                r_alo     <= i_addr_low;
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
                r_found   <= 1'b0;
                r_refused <= 1'b0;
                r_rfam    <= '0;
                r_rhi     <= '0;
                r_rlo     <= '0;
            end
            ncae_pkg::OP_SCAN_CHK: begin
                if (w_rd_valid && !r_hit && (r_rd.key == r_key)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_hit_t   <= r_rd.t;
                    // only a lookup returns the stored address
                    if (!r_is_ins) begin
                        r_found <= 1'b1;
                        r_rfam  <= r_rd.fam;
                        r_rhi   <= r_rd.ahi;
                        r_rlo   <= r_rd.alo;
                    end
                end
                if (!w_rd_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
            ncae_pkg::OP_DIV_INIT: begin
                r_rem_num <= r_sum;
                r_rem     <= '0;
                r_quo     <= '0;
                r_div_cnt <= '0;
            end
            ncae_pkg::OP_DIV_STEP: begin
                r_rem_num <= {r_rem_num[SW-2:0], 1'b0};
                r_div_cnt <= r_div_cnt + DW'(1);
                if (w_trial >= {1'b0, r_count}) begin
                    r_rem <= CW'(w_trial - {1'b0, r_count});
                    r_quo <= {r_quo[SW-2:0], 1'b1};
                end else begin
                    r_rem <= CW'(w_trial);
                    r_quo <= {r_quo[SW-2:0], 1'b0};
                end
            end
            ncae_pkg::OP_REFUSE: r_refused <= 1'b1;
            default: ;
        endcase
    end

    assign o_found            = r_found;
    assign o_result_family    = r_rfam;
    assign o_result_addr_high = r_rhi;
    assign o_result_addr_low  = r_rlo;
    assign o_insert_refused   = r_refused;
    assign o_entries_in_use   = 9'(r_count);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");
    a_write_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ncae_pkg::OP_WRITE) |-> (r_hit || r_free))
        else $error("write without slot");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ncae_pkg::OP_HIT) |=> $stable(r_count))
        else $error("lookup changed entry count");

endmodule

/* sv/name_cache_average_age_evict_top.sv */
// ----------------------------------------------------------------------------
// name_cache_average_age_evict_top: name-to-address cache, average-age evict
// Lookup refreshes entry time; insert into a full table sweeps old entries.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | i_in_valid / o_in_ready | cmd, name_key, now_seconds, addr
//  out     | o_out_valid/i_out_ready | found, result addr, refused, count
//
//  One item at a time. Lookup or insert: a table scan (one memory read
//  port, a read state and a check state per entry) plus result.
//  Insert into a full table adds a divider pass, a sweep of the table
//  (skipped when the threshold wraps) and a recheck state; a refusal
//  there skips the scan. Reset clears valid bits at once; no clearing
//  pass.
//  Output stalls hold the result and block the next input transfer.
module name_cache_average_age_evict_top #(
    parameter int CAPACITY   = 256,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_name_key,
    input  logic [31:0] i_now_seconds,
    input  logic [1:0]  i_addr_family,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [1:0]  o_result_family,
    output logic [63:0] o_result_addr_high,
    output logic [63:0] o_result_addr_low,
    output logic        o_insert_refused,
    output logic [8:0]  o_entries_in_use
);

    ncae_pkg::t_cmd    w_cmd;
    ncae_pkg::t_status w_status;

    ncae_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(w_status), .o_cmd(w_cmd)
    );

    ncae_dp #(.CAPACITY(CAPACITY), .TIME_WIDTH(TIME_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_cmd_bit(i_cmd), .i_name_key, .i_now_seconds, .i_addr_family,
        .i_addr_high, .i_addr_low, .o_found, .o_result_family,
        .o_result_addr_high, .o_result_addr_low, .o_insert_refused,
        .o_entries_in_use
    );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the name cache with average-age eviction
// A queue-fed driver offers lookups and inserts; a shadow table predicts each
// result and the monitor compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  NSLOTS    = 256;
    localparam int  RUN_LIMIT = 3000000;
    localparam logic [31:0] T_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic        cmd;
        logic [63:0] key;
        logic [31:0] now;
        logic [1:0]  fam;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          drain;  // wait for an empty pipeline before offering
    } t_req;

    typedef struct {
        logic        found;
        logic [1:0]  fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        refused;
        logic [8:0]  count;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    logic cmd = 1'b0;
    logic [63:0] name_key = '0;
    logic [31:0] now_s = '0;
    logic [1:0]  addr_fam = '0;
    logic [63:0] addr_hi = '0;
    logic [63:0] addr_lo = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    logic        o_found;
    logic [1:0]  o_result_family;
    logic [63:0] o_result_addr_high;
    logic [63:0] o_result_addr_low;
    logic        o_insert_refused;
    logic [8:0]  o_entries_in_use;

    name_cache_average_age_evict_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_cmd(cmd), .i_name_key(name_key), .i_now_seconds(now_s),
        .i_addr_family(addr_fam), .i_addr_high(addr_hi), .i_addr_low(addr_lo),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_found(o_found), .o_result_family(o_result_family),
        .o_result_addr_high(o_result_addr_high), .o_result_addr_low(o_result_addr_low),
        .o_insert_refused(o_insert_refused), .o_entries_in_use(o_entries_in_use)
    );

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    logic [63:0] issued_keys[$];
    int    err_cnt = 0;
    int    resp_cnt = 0;
    int    cyc = 0;
    int    hold_left = 0;
    bit    hold_done = 0;

    // shadow cache
    bit          sh_valid[NSLOTS];
    logic [63:0] sh_key[NSLOTS];
    logic [1:0]  sh_fam[NSLOTS];
    logic [63:0] sh_hi[NSLOTS];
    logic [63:0] sh_lo[NSLOTS];
    logic [31:0] sh_used[NSLOTS];
    logic [63:0] sh_sum = '0;
    logic [31:0] sh_thr = '0;
    int          sh_count = 0;

    function automatic int find_slot(logic [63:0] key);
        for (int i = 0; i < NSLOTS; i++)
            if (sh_valid[i] && sh_key[i] == key) return i;
        return -1;
    endfunction

    function automatic t_resp cache_step(t_req r);
        t_resp res;
        int slot;
        res = '{default: '0};
        slot = -1;
        if (r.cmd == ncae_pkg::CMD_LOOKUP) begin
            slot = find_slot(r.key);
            if (slot >= 0) begin
                sh_sum = sh_sum - sh_used[slot] + r.now;
                sh_used[slot] = r.now;
                res.found = 1'b1;
                res.fam = sh_fam[slot];
                res.hi = sh_hi[slot];
                res.lo = sh_lo[slot];
            end
        end else begin
            // full table: set threshold from the average age, then sweep
            if (sh_count >= NSLOTS) begin
                sh_thr = 32'(sh_sum / 64'(sh_count) + 64'd1);
                if (sh_thr != 0)
                    for (int i = 0; i < NSLOTS; i++)
                        if (sh_valid[i] && sh_used[i] < sh_thr) begin
                            sh_valid[i] = 0;
                            sh_sum -= sh_used[i];
                            sh_count--;
                        end
            end
            if (sh_count >= NSLOTS) begin
                res.refused = 1'b1;
            end else begin
                slot = find_slot(r.key);
                if (slot >= 0) begin
                    sh_sum -= sh_used[slot];
                end else begin
                    for (int i = 0; i < NSLOTS && slot < 0; i++)
                        if (!sh_valid[i]) slot = i;
                    sh_valid[slot] = 1;
                    sh_key[slot] = r.key;
                    sh_count++;
                end
                sh_fam[slot] = r.fam;
                sh_hi[slot] = r.hi;
                sh_lo[slot] = r.lo;
                sh_used[slot] = r.now;
                sh_sum += r.now;
            end
        end
        res.count = 9'(sh_count);
        return res;
    endfunction

    task automatic add_req(logic c, logic [63:0] k, logic [31:0] t, logic [1:0] f,
                           logic [63:0] h, logic [63:0] l, bit d = 0);
        t_req r;
        r = '{cmd: c, key: k, now: t, fam: f, hi: h, lo: l, drain: d};
        pending_reqs.push_back(r);
        if (c == ncae_pkg::CMD_INSERT) issued_keys.push_back(k);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // no idling in this window
    function automatic bit calm();
        return cyc >= 150000 && cyc < 250000;
    endfunction

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver: account for the transfer, then offer the next request or idle
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                expected_resps.push_back(cache_step('{cmd: cmd, key: name_key,
                    now: now_s, fam: addr_fam, hi: addr_hi, lo: addr_lo, drain: 0}));
            if (!in_valid || o_in_ready) begin
                if (pending_reqs.size() > 0
                        && !(pending_reqs[0].drain && expected_resps.size() != 0)
                        && (calm() || $urandom_range(99) >= 17)) begin
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    cmd <= r.cmd;
                    name_key <= r.key;
                    now_s <= r.now;
                    addr_fam <= r.fam;
                    addr_hi <= r.hi;
                    addr_lo <= r.lo;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output transfer, then decide ready
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                resp_cnt++;
                if (expected_resps.size() == 0) begin
                    $error("unexpected result transfer");
                    err_cnt++;
                end else begin
                    e = expected_resps.pop_front();
                    if (o_found !== e.found) begin
                        $error("found: expected %0d, got %0d", e.found, o_found);
                        err_cnt++;
                    end
                    if (o_result_family !== e.fam) begin
                        $error("result_family: expected %0d, got %0d", e.fam,
                               o_result_family);
                        err_cnt++;
                    end
                    if (o_result_addr_high !== e.hi) begin
                        $error("result_addr_high: expected %h, got %h", e.hi,
                               o_result_addr_high);
                        err_cnt++;
                    end
                    if (o_result_addr_low !== e.lo) begin
                        $error("result_addr_low: expected %h, got %h", e.lo,
                               o_result_addr_low);
                        err_cnt++;
                    end
                    if (o_insert_refused !== e.refused) begin
                        $error("insert_refused: expected %0d, got %0d", e.refused,
                               o_insert_refused);
                        err_cnt++;
                    end
                    if (o_entries_in_use !== e.count) begin
                        $error("entries_in_use: expected %0d, got %0d", e.count,
                               o_entries_in_use);
                        err_cnt++;
                    end
                end
            end
            // long hold-off once, while the sender keeps offering
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && resp_cnt >= 300) begin
                hold_done <= 1;
                hold_left <= 4000;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm() || $urandom_range(99) >= 17;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [63:0] ka;
        logic [31:0] tnow;
        logic [63:0] k;
        for (int i = 0; i < NSLOTS; i++) sh_valid[i] = 0;
        ka = rand64();

        // directed: extremes, hit, miss, refresh, overwrite of an existing key
        add_req(ncae_pkg::CMD_LOOKUP, '0, '0, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_INSERT, '0, T_MAX, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_INSERT, '1, T_MAX, 2'd2, '1, '1);
        add_req(ncae_pkg::CMD_INSERT, ka, T_MAX, 2'd1, '0, {32'd0, $urandom});
        add_req(ncae_pkg::CMD_LOOKUP, '0, T_MAX, 2'd1, '1, '1);
        add_req(ncae_pkg::CMD_LOOKUP, '1, '0, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_LOOKUP, '1, T_MAX, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_INSERT, ka, T_MAX, 2'd2, rand64(), rand64());
        add_req(ncae_pkg::CMD_LOOKUP, ka, T_MAX, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_LOOKUP, rand64(), $urandom, 2'd0, '0, '0);

        // fill the table with every entry at the top time
        for (int i = 0; i < NSLOTS - 3; i++)
            add_req(ncae_pkg::CMD_INSERT, rand64(), T_MAX, 2'($urandom_range(2)),
                    rand64(), rand64());
        // threshold wraps: refused, also for a key already present
        add_req(ncae_pkg::CMD_INSERT, rand64(), T_MAX, 2'd1, rand64(), rand64());
        add_req(ncae_pkg::CMD_INSERT, ka, T_MAX, 2'd1, rand64(), rand64());
        // age one entry so the next full insert sweeps it out
        add_req(ncae_pkg::CMD_LOOKUP, ka, 32'd5, 2'd0, '0, '0);
        add_req(ncae_pkg::CMD_INSERT, rand64(), 32'd7, 2'd2, rand64(), rand64());

        // random mix; the first request waits for an idle block
        tnow = 32'd1000;
        for (int i = 0; i < 180; i++) begin
            tnow = tnow + $urandom_range(50);
            if ($urandom_range(99) < 50) begin
                if ($urandom_range(99) < 70) k = rand64();
                else k = issued_keys[$urandom_range(issued_keys.size() - 1)];
                add_req(ncae_pkg::CMD_INSERT, k,
                        ($urandom_range(99) < 80) ? tnow : $urandom,
                        2'($urandom_range(2)), rand64(), rand64(), i == 0);
            end else begin
                if ($urandom_range(99) < 75)
                    k = issued_keys[$urandom_range(issued_keys.size() - 1)];
                else k = rand64();
                add_req(ncae_pkg::CMD_LOOKUP, k,
                        ($urandom_range(99) < 80) ? tnow : $urandom,
                        2'($urandom_range(3)), rand64(), rand64(), i == 0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then let the block settle
        forever begin
            @(posedge i_clk);
            if (pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0)
                break;
        end
        repeat (1200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
